// ----- rtl/dgt_pkg.sv -----
// Shared types, constants and register indexes for the downscale/threshold block.
`default_nettype none

package dgt_pkg;

    // Configuration register widths and reset values
    localparam int CFG_W       = 13;
    localparam int THR_W       = 8;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd400;
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd240;
    localparam logic [THR_W-1:0] THRESHOLD_RST  = 8'd127;

    // Default geometry
    localparam int DEF_OUT_WIDTH   = 400;
    localparam int DEF_OUT_HEIGHT  = 240;
    localparam int DEF_MAX_SRC_DIM = 4096;

    // Stream field widths
    localparam int CHAN_W      = 8;
    localparam int COL_W       = 9;
    localparam int ROW_W       = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Luma weights, 0.299 / 0.587 / 0.114 in unsigned 0.16
    localparam int LUMA_SUM_W = 24;
    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;

    // Cycles the derived step values need after a register write
    localparam int SETTLE_W = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SRC_WIDTH      = 2'd0,
        REG_SRC_HEIGHT     = 2'd1,
        REG_LUMA_THRESHOLD = 2'd2
    } dgt_reg_t;

    // Selection result for the item in the input register
    typedef struct packed {
        logic             hit;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } dgt_pick_t;

endpackage

`default_nettype wire

// ----- rtl/dgt_step_div.sv -----
// Clamps one source dimension and splits it into quotient and remainder by the output size.
`default_nettype none

module dgt_step_div
    import dgt_pkg::*;
#(
    parameter int DIVISOR = DEF_OUT_WIDTH,
    parameter int EFF_MAX = DEF_MAX_SRC_DIM,
    parameter int DIM_W   = 13,
    parameter int REM_W   = 9
)
(
    input  wire logic             clk,
    input  wire logic [CFG_W-1:0] dim_raw,
    output logic      [DIM_W-1:0] dim_eff,
    output logic      [DIM_W-1:0] quot,
    output logic      [REM_W-1:0] rem
);

    localparam int     SHIFT   = CFG_W + $clog2(DIVISOR);
    localparam longint RECIP   = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int     RECIP_W = $clog2(RECIP + 1);
    localparam int     PROD_W  = DIM_W + RECIP_W;
    localparam int     DIV_W   = $clog2(DIVISOR + 1);
    localparam int     BACK_W  = DIM_W + DIV_W;

    logic [31:0]       v_lo;
    logic [DIM_W-1:0]  eff_reg;
    logic [DIM_W-1:0]  eff_next;
    logic [PROD_W-1:0] recip_prod;
    logic [DIM_W-1:0]  quot_reg;
    logic [DIM_W-1:0]  quot_next;
    logic [BACK_W-1:0] back_prod;
    logic [DIM_W-1:0]  rem_full;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;

    // Lower bound first, then the upper bound wins
    always_comb
    begin
        v_lo = (32'(dim_raw) < 32'(DIVISOR)) ? 32'(DIVISOR) : 32'(dim_raw);
        if (v_lo > 32'(EFF_MAX))
        begin
            eff_next = DIM_W'(EFF_MAX);
        end
        else
        begin
            eff_next = DIM_W'(v_lo);
        end
    end

    // Exact quotient by reciprocal for any value below 2**CFG_W
    assign recip_prod = PROD_W'(eff_reg) * PROD_W'(RECIP);
    assign quot_next  = DIM_W'(recip_prod >> SHIFT);

    assign back_prod = BACK_W'(quot_reg) * BACK_W'(DIVISOR);
    assign rem_full  = eff_reg - DIM_W'(back_prod);
    assign rem_next  = REM_W'(rem_full);

    always_ff @(posedge clk)
    begin
        eff_reg  <= eff_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign dim_eff = eff_reg;
    assign quot    = quot_reg;
    assign rem     = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/dgt_scan.sv -----
// Source and output position counters that pick the nearest-neighbor samples.
`default_nettype none

module dgt_scan
    import dgt_pkg::*;
#(
    parameter int OUT_WIDTH  = DEF_OUT_WIDTH,
    parameter int OUT_HEIGHT = DEF_OUT_HEIGHT,
    parameter int DIM_W      = 13,
    parameter int CREM_W     = 9,
    parameter int LREM_W     = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              start_frame,
    input  wire logic [DIM_W-1:0]  w_eff,
    input  wire logic [DIM_W-1:0]  h_eff,
    input  wire logic [DIM_W-1:0]  w_quot,
    input  wire logic [CREM_W-1:0] w_rem,
    input  wire logic [DIM_W-1:0]  h_quot,
    input  wire logic [LREM_W-1:0] h_rem,
    output dgt_pick_t              pick
);

    localparam int OC_W = $clog2(OUT_WIDTH + 1);
    localparam int OL_W = $clog2(OUT_HEIGHT + 1);

    logic [DIM_W-1:0]  src_col_reg, src_col_next;
    logic [DIM_W-1:0]  src_line_reg, src_line_next;
    logic [OC_W-1:0]   out_col_reg, out_col_next;
    logic [OL_W-1:0]   out_line_reg, out_line_next;
    logic [DIM_W-1:0]  want_col_reg, want_col_next;
    logic [DIM_W-1:0]  want_line_reg, want_line_next;
    logic [CREM_W-1:0] col_rem_reg, col_rem_next;
    logic [LREM_W-1:0] line_rem_reg, line_rem_next;

    logic [DIM_W-1:0]  sc, sl, wc, wl;
    logic [OC_W-1:0]   oc, oc_inc;
    logic [OL_W-1:0]   ol, ol_inc;
    logic [CREM_W-1:0] cr;
    logic [LREM_W-1:0] lr;
    logic [CREM_W:0]   col_sum;
    logic [LREM_W:0]   line_sum;
    logic [DIM_W:0]    sc_inc, sl_inc;
    logic              row_active;
    logic              hit;

    always_comb
    begin
        // Start mark restarts every counter before this pixel is looked at
        sc = start_frame ? '0 : src_col_reg;
        sl = start_frame ? '0 : src_line_reg;
        oc = start_frame ? '0 : out_col_reg;
        ol = start_frame ? '0 : out_line_reg;
        wc = start_frame ? '0 : want_col_reg;
        wl = start_frame ? '0 : want_line_reg;
        cr = start_frame ? '0 : col_rem_reg;
        lr = start_frame ? '0 : line_rem_reg;

        row_active = (ol < OL_W'(OUT_HEIGHT)) && (sl == wl);
        hit        = row_active && (oc < OC_W'(OUT_WIDTH)) && (sc == wc);

        pick.hit  = hit;
        pick.col  = COL_W'(oc);
        pick.row  = ROW_W'(ol);
        pick.last = (oc == OC_W'(OUT_WIDTH - 1)) && (ol == OL_W'(OUT_HEIGHT - 1));

        oc_inc   = oc + OC_W'(1);
        ol_inc   = ol + OL_W'(1);
        col_sum  = {1'b0, cr} + {1'b0, w_rem};
        line_sum = {1'b0, lr} + {1'b0, h_rem};
        sc_inc   = {1'b0, sc} + (DIM_W+1)'(1);
        sl_inc   = {1'b0, sl} + (DIM_W+1)'(1);

        src_col_next   = sc;
        src_line_next  = sl;
        out_col_next   = oc;
        out_line_next  = ol;
        want_col_next  = wc;
        want_line_next = wl;
        col_rem_next   = cr;
        line_rem_next  = lr;

        if (hit)
        begin
            out_col_next = oc_inc;
            if (oc_inc < OC_W'(OUT_WIDTH))
            begin
                if (col_sum >= (CREM_W+1)'(OUT_WIDTH))
                begin
                    col_rem_next  = CREM_W'(col_sum - (CREM_W+1)'(OUT_WIDTH));
                    want_col_next = wc + w_quot + DIM_W'(1);
                end
                else
                begin
                    col_rem_next  = CREM_W'(col_sum);
                    want_col_next = wc + w_quot;
                end
            end
        end

        if (sc_inc >= {1'b0, w_eff})
        begin
            // End of source line
            src_col_next  = '0;
            out_col_next  = '0;
            want_col_next = '0;
            col_rem_next  = '0;
            if (row_active)
            begin
                out_line_next = ol_inc;
                if (ol_inc < OL_W'(OUT_HEIGHT))
                begin
                    if (line_sum >= (LREM_W+1)'(OUT_HEIGHT))
                    begin
                        line_rem_next  = LREM_W'(line_sum - (LREM_W+1)'(OUT_HEIGHT));
                        want_line_next = wl + h_quot + DIM_W'(1);
                    end
                    else
                    begin
                        line_rem_next  = LREM_W'(line_sum);
                        want_line_next = wl + h_quot;
                    end
                end
            end
            if (sl_inc >= {1'b0, h_eff})
            begin
                // End of source frame: wrap everything
                src_line_next  = '0;
                out_line_next  = '0;
                want_line_next = '0;
                line_rem_next  = '0;
            end
            else
            begin
                src_line_next = DIM_W'(sl_inc);
            end
        end
        else
        begin
            src_col_next = DIM_W'(sc_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_line_reg  <= '0;
            out_col_reg   <= '0;
            out_line_reg  <= '0;
            want_col_reg  <= '0;
            want_line_reg <= '0;
            col_rem_reg   <= '0;
            line_rem_reg  <= '0;
        end
        else if (advance)
        begin
            src_col_reg   <= src_col_next;
            src_line_reg  <= src_line_next;
            out_col_reg   <= out_col_next;
            out_line_reg  <= out_line_next;
            want_col_reg  <= want_col_next;
            want_line_reg <= want_line_next;
            col_rem_reg   <= col_rem_next;
            line_rem_reg  <= line_rem_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dgt_luma.sv -----
// Luma of one RGB pixel as an 8.16 fixed-point sum of unsigned 0.16 weights, compared against the threshold.
`default_nettype none

module dgt_luma
    import dgt_pkg::*;
(
    input  wire logic [CHAN_W-1:0] red,
    input  wire logic [CHAN_W-1:0] green,
    input  wire logic [CHAN_W-1:0] blue,
    input  wire logic [THR_W-1:0]  threshold,
    output logic                   mono_bit
);

    logic [LUMA_SUM_W-1:0] luma_sum;
    logic [CHAN_W-1:0]     luma;

    assign luma_sum = LUMA_SUM_W'(COEF_R) * LUMA_SUM_W'(red)
                    + LUMA_SUM_W'(COEF_G) * LUMA_SUM_W'(green)
                    + LUMA_SUM_W'(COEF_B) * LUMA_SUM_W'(blue);

    // Truncate the fraction
    assign luma     = luma_sum[LUMA_SUM_W-1 -: CHAN_W];
    assign mono_bit = (luma > threshold);

endmodule

`default_nettype wire

// ----- rtl/downscale_gray_threshold_core.sv -----
// Top level: config registers, input and result registers, scan, luma and step dividers.
`default_nettype none

// Takes RGB pixels in raster order (tuser marks the first pixel of a frame) and emits one
// thresholded luma bit, with its output column and row, for each pixel that the
// nearest-neighbor scan selects; other pixels give no transfer. One pixel is taken every
// clock while the output side keeps up and no settling is in progress; a selected pixel
// passes through the input register, then the result register, to the master side. After
// reset and after any configuration write, the input holds tready low while the width and
// height step values pass through the clamp / reciprocal / remainder pipeline.

module downscale_gray_threshold_core
    import dgt_pkg::*;
#(
    parameter int OUT_WIDTH   = DEF_OUT_WIDTH,
    parameter int OUT_HEIGHT  = DEF_OUT_HEIGHT,
    parameter int MAX_SRC_DIM = DEF_MAX_SRC_DIM
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // red, green, blue
    input  wire logic                   s_axis_tuser,  // start_frame

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // mono_bit, out_col, out_row, zero pad
    output logic                        m_axis_tlast,  // frame_end

    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int EFF_MAX = (MAX_SRC_DIM < (1 << CFG_W)) ? MAX_SRC_DIM : (1 << CFG_W) - 1;
    localparam int DIM_W   = $clog2(EFF_MAX + 1);
    localparam int CREM_W  = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
    localparam int LREM_W  = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;
    localparam int PAD_W   = OUT_TDATA_W - 1 - COL_W - ROW_W;

    logic [CFG_W-1:0]    src_width_reg;
    logic [CFG_W-1:0]    src_height_reg;
    logic [THR_W-1:0]    luma_threshold_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic                settle_busy;

    logic                in_valid_reg;
    logic                in_start_reg;
    logic [CHAN_W-1:0]   in_red_reg;
    logic [CHAN_W-1:0]   in_green_reg;
    logic [CHAN_W-1:0]   in_blue_reg;

    logic                out_valid_reg;
    logic                out_mono_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic                out_last_reg;

    logic                s_xfer;
    logic                advance;
    logic                mono_bit;
    dgt_pick_t           pick;

    logic [DIM_W-1:0]    w_eff, h_eff, w_quot, h_quot;
    logic [CREM_W-1:0]   w_rem;
    logic [LREM_W-1:0]   h_rem;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg      <= SRC_WIDTH_RST;
            src_height_reg     <= SRC_HEIGHT_RST;
            luma_threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:      src_width_reg      <= cfg_data;
                REG_SRC_HEIGHT:     src_height_reg     <= cfg_data;
                REG_LUMA_THRESHOLD: luma_threshold_reg <= THR_W'(cfg_data);
                default:            ;
            endcase
        end
    end

    // Hold off input until the step values reflect the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_CYCLES;
        end
        else if (cfg_we)
        begin
            settle_reg <= SETTLE_CYCLES;
        end
        else if (settle_busy)
        begin
            settle_reg <= settle_reg - SETTLE_W'(1);
        end
    end

    assign settle_busy = (settle_reg != '0);

    dgt_step_div #(
        .DIVISOR (OUT_WIDTH),
        .EFF_MAX (EFF_MAX),
        .DIM_W   (DIM_W),
        .REM_W   (CREM_W)
    ) u_width_div (
        .clk     (clk),
        .dim_raw (src_width_reg),
        .dim_eff (w_eff),
        .quot    (w_quot),
        .rem     (w_rem)
    );

    dgt_step_div #(
        .DIVISOR (OUT_HEIGHT),
        .EFF_MAX (EFF_MAX),
        .DIM_W   (DIM_W),
        .REM_W   (LREM_W)
    ) u_height_div (
        .clk     (clk),
        .dim_raw (src_height_reg),
        .dim_eff (h_eff),
        .quot    (h_quot),
        .rem     (h_rem)
    );

    // Handshake
    assign advance       = in_valid_reg && !settle_busy && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !settle_busy && (!in_valid_reg || !out_valid_reg || m_axis_tready);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_start_reg <= s_axis_tuser;
            in_red_reg   <= s_axis_tdata[CHAN_W-1:0];
            in_green_reg <= s_axis_tdata[2*CHAN_W-1:CHAN_W];
            in_blue_reg  <= s_axis_tdata[3*CHAN_W-1:2*CHAN_W];
        end
    end

    dgt_scan #(
        .OUT_WIDTH   (OUT_WIDTH),
        .OUT_HEIGHT  (OUT_HEIGHT),
        .DIM_W       (DIM_W),
        .CREM_W      (CREM_W),
        .LREM_W      (LREM_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .start_frame (in_start_reg),
        .w_eff       (w_eff),
        .h_eff       (h_eff),
        .w_quot      (w_quot),
        .w_rem       (w_rem),
        .h_quot      (h_quot),
        .h_rem       (h_rem),
        .pick        (pick)
    );

    dgt_luma u_luma (
        .red       (in_red_reg),
        .green     (in_green_reg),
        .blue      (in_blue_reg),
        .threshold (luma_threshold_reg),
        .mono_bit  (mono_bit)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= pick.hit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pick.hit)
        begin
            out_mono_reg <= mono_bit;
            out_col_reg  <= pick.col;
            out_row_reg  <= pick.row;
            out_last_reg <= pick.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {PAD_W'(0), out_row_reg, out_col_reg, out_mono_reg};
    assign m_axis_tlast  = out_last_reg;

    // Checks
    a_no_advance_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !advance)
        else $error("item processed while step values were settling");

    a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without an item being processed");

    a_last_at_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |->
            (out_col_reg == COL_W'(OUT_WIDTH - 1)) && (out_row_reg == ROW_W'(OUT_HEIGHT - 1)))
        else $error("frame end flagged away from the last output pixel");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the downscale/threshold core: stream stimulus, luma/scan predictor, checks.
`timescale 1ns / 100ps

module tb_top;
    import dgt_pkg::*;

    localparam int OUT_W   = DEF_OUT_WIDTH;
    localparam int OUT_H   = DEF_OUT_HEIGHT;
    localparam int MAX_DIM = DEF_MAX_SRC_DIM;

    // 0.299 / 0.587 / 0.114 in unsigned 0.16; they sum to 65536, so gray v has luma v
    localparam logic [23:0] WEIGHT_R = 24'd19595;
    localparam logic [23:0] WEIGHT_G = 24'd38470;
    localparam logic [23:0] WEIGHT_B = 24'd7471;

    typedef struct packed {
        logic             mono;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             frame_end;
    } mono_pixel_t;

    class downscale_predictor;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        logic [THR_W-1:0] thr_reg;
        logic [11:0]      src_col;
        logic [11:0]      src_line;
        logic [11:0]      want_col;
        logic [11:0]      want_line;
        logic [8:0]       out_col;
        logic [8:0]       col_rem;
        logic [7:0]       out_line;
        logic [7:0]       line_rem;
        mono_pixel_t      due_pixels[$];
        int               errors;

        function new();
            width_reg  = SRC_WIDTH_RST;
            height_reg = SRC_HEIGHT_RST;
            thr_reg    = THRESHOLD_RST;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            src_col   = '0;
            src_line  = '0;
            want_col  = '0;
            want_line = '0;
            out_col   = '0;
            col_rem   = '0;
            out_line  = '0;
            line_rem  = '0;
        endfunction

        function void set_reg(dgt_reg_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_SRC_WIDTH:      width_reg = value;
                REG_SRC_HEIGHT:     height_reg = value;
                REG_LUMA_THRESHOLD: thr_reg = value[THR_W-1:0];
                default:            ;
            endcase
        endfunction

        function logic [CFG_W-1:0] fit_dim(logic [CFG_W-1:0] v, int lo);
            if (v < lo)
                return CFG_W'(lo);
            if (v > MAX_DIM)
                return CFG_W'(MAX_DIM);
            return v;
        endfunction

        // Advance the scan by one source pixel; queue the output pixel it selects, if any.
        function void note_pixel(logic sof, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            logic [CFG_W-1:0] w;
            logic [CFG_W-1:0] h;
            logic             row_on;
            logic [23:0]      luma_sum;
            logic [9:0]       col_sum;
            logic [8:0]       line_sum;
            mono_pixel_t      pix;
            w = fit_dim(width_reg, OUT_W);
            h = fit_dim(height_reg, OUT_H);
            if (sof)
                restart();
            row_on = (out_line < OUT_H) && (src_line == want_line);
            if (row_on && out_col < OUT_W && src_col == want_col)
            begin
                luma_sum = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
                pix.mono      = luma_sum[23:16] > thr_reg;
                pix.col       = out_col;
                pix.row       = out_line;
                pix.frame_end = (out_col == OUT_W - 1) && (out_line == OUT_H - 1);
                due_pixels.push_back(pix);
                out_col = out_col + 9'd1;
                if (out_col < OUT_W)
                begin
                    want_col = want_col + 12'(w / OUT_W);
                    col_sum  = 10'(col_rem) + 10'(w % OUT_W);
                    if (col_sum >= OUT_W)
                    begin
                        col_sum  = col_sum - 10'(OUT_W);
                        want_col = want_col + 12'd1;
                    end
                    col_rem = col_sum[8:0];
                end
            end
            if ({1'b0, src_col} + 13'd1 >= w)
            begin
                src_col  = '0;
                out_col  = '0;
                want_col = '0;
                col_rem  = '0;
                if (row_on)
                begin
                    out_line = out_line + 8'd1;
                    if (out_line < OUT_H)
                    begin
                        want_line = want_line + 12'(h / OUT_H);
                        line_sum  = 9'(line_rem) + 9'(h % OUT_H);
                        if (line_sum >= OUT_H)
                        begin
                            line_sum  = line_sum - 9'(OUT_H);
                            want_line = want_line + 12'd1;
                        end
                        line_rem = line_sum[7:0];
                    end
                end
                if ({1'b0, src_line} + 13'd1 >= h)
                    restart();
                else
                    src_line = src_line + 12'd1;
            end
            else
            begin
                src_col = src_col + 12'd1;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(logic [OUT_TDATA_W-1:0] data, logic last);
            mono_pixel_t want;
            if (due_pixels.size() == 0)
            begin
                $error("unexpected result transfer: tdata=%h tlast=%b", data, last);
                errors++;
                return;
            end
            want = due_pixels.pop_front();
            compare_field("mono_bit", want.mono, data[0]);
            compare_field("out_col", want.col, data[COL_W:1]);
            compare_field("out_row", want.row, data[COL_W+ROW_W:COL_W+1]);
            compare_field("frame_end", want.frame_end, last);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // red, green, blue
    logic                   s_axis_tuser;   // start_frame
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // mono_bit, out_col, out_row, zero pad
    logic                   m_axis_tlast;   // frame_end
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    downscale_predictor board;
    int                 idle_odds;   // 0: no idling, else one burst in idle_odds

    downscale_gray_threshold_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: stall in random bursts while idling is on.
    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready = 1'b0;
            end
            else if (rst_n && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                hold = $urandom_range(1, 7) - 1;
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_pixel(m_axis_tdata, m_axis_tlast);
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_pixel(input logic sof, input logic [23:0] rgb);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = rgb;
        s_axis_tuser  = sof;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_pixel(sof, rgb[7:0], rgb[15:8], rgb[23:16]);
        @(negedge clk);
    endtask

    // Hold the stream until every queued result has come, then let tail cycles pass.
    task automatic drain_results(input int tail);
        s_axis_tvalid = 1'b0;
        while (board.due_pixels.size() != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_reg(input dgt_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        board.set_reg(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_dim(input int out_size);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_W'(out_size);
            2:       return CFG_W'(out_size + 1);
            3:       return '1;
            4:       return CFG_W'($urandom_range(out_size, 1200));
            default: return CFG_W'($urandom_range(0, 8191));
        endcase
    endfunction

    function automatic logic [23:0] pick_rgb();
        logic [7:0] v;
        if ($urandom_range(0, 3) == 0)
        begin
            // gray right at or just above the threshold
            v = board.thr_reg + 8'($urandom_range(0, 1));
            return {v, v, v};
        end
        return 24'($urandom);
    endfunction

    initial
    begin
        int phase;
        int count;
        int k;
        board         = new();
        idle_odds     = 8;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SRC_WIDTH;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: every source pixel maps to one output pixel.
        push_pixel(1'b1, 24'h7F7F7F);
        push_pixel(1'b0, 24'h808080);
        push_pixel(1'b0, 24'h0000FF);
        push_pixel(1'b0, 24'h00FF00);
        push_pixel(1'b0, 24'hFF0000);
        push_pixel(1'b0, 24'hFFFFFF);
        push_pixel(1'b0, 24'h000000);
        push_pixel(1'b0, 24'h55AA55);
        push_pixel(1'b0, 24'hAA55AA);
        push_pixel(1'b1, 24'hFFFFFF);   // restart mid-line
        push_pixel(1'b0, 24'h00FFFF);
        drain_results(6);
        write_reg(REG_LUMA_THRESHOLD, 13'd0);
        push_pixel(1'b0, 24'h000000);
        push_pixel(1'b0, 24'h010101);
        drain_results(6);
        write_reg(REG_LUMA_THRESHOLD, 13'h1FFF);   // upper bits drop, threshold 255
        push_pixel(1'b0, 24'hFFFFFF);
        push_pixel(1'b0, 24'hFEFEFE);
        drain_results(6);

        // Short runs under changing sizes, some continuing the previous frame.
        for (phase = 0; phase < 12; phase++)
        begin
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
            case (phase)
                0:
                begin
                    write_reg(REG_SRC_WIDTH, 13'd0);
                    write_reg(REG_SRC_HEIGHT, 13'd0);
                end
                1:
                begin
                    write_reg(REG_SRC_WIDTH, 13'h1FFF);
                    write_reg(REG_SRC_HEIGHT, 13'h1FFF);
                end
                2:
                begin
                    write_reg(REG_SRC_WIDTH, CFG_W'(MAX_DIM));
                    write_reg(REG_SRC_HEIGHT, CFG_W'(MAX_DIM));
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 1)
                        write_reg(REG_SRC_WIDTH, pick_dim(OUT_W));
                    if ($urandom_range(0, 1) == 1)
                        write_reg(REG_SRC_HEIGHT, pick_dim(OUT_H));
                end
            endcase
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_LUMA_THRESHOLD, CFG_W'($urandom_range(0, 8191)));
            count = $urandom_range(12, 30);
            for (k = 0; k < count; k++)
            begin
                if (phase == 0 && k == count / 2)
                    drain_results(0);
                push_pixel((k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 79) == 0,
                           pick_rgb());
            end
            drain_results(6);
        end

        // One source line somewhat wider than the output, then into the next line.
        idle_odds = 6;
        write_reg(REG_SRC_WIDTH, CFG_W'(OUT_W + 37));
        write_reg(REG_SRC_HEIGHT, CFG_W'(OUT_H + 1));
        push_pixel(1'b1, pick_rgb());
        for (k = 1; k < OUT_W + 37; k++)
            push_pixel(1'b0, pick_rgb());

        // Tail of the run with no idling on either side.
        idle_odds = 0;
        for (k = 0; k < 130; k++)
            push_pixel(1'b0, pick_rgb());
        drain_results(10);

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dgt_pkg.sv
rtl/dgt_step_div.sv
rtl/dgt_scan.sv
rtl/dgt_luma.sv
rtl/downscale_gray_threshold_core.sv
tb/tb_top.sv
